// ----- sv/ssprx_pkg.sv -----
// Package with the shared types and constants of the servo status packet receiver.
package ssprx_pkg;

    // The largest packet length that is kept; longer requests are clamped.
    localparam int PACKET_BYTES_MAX = 32;

    // Field widths are fixed by the interface.
    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int KEPT_W   = 6;
    localparam int SKIP_W   = 4;
    localparam int VALUE_W  = 16;

    // Function codes of an input word.
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_IDLE  = 2'd2;

    // Packet layout.
    localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hFF;
    localparam logic [BYTE_W-1:0] SUM_GOOD     = 8'hFF;
    localparam logic [KEPT_W-1:0] HDR_BYTES    = 6'd6;
    localparam logic [KEPT_W-1:0] SUM_FIRST_IX = 6'd2;
    localparam logic [KEPT_W-1:0] ERROR_IX     = 6'd4;
    localparam logic [KEPT_W-1:0] VALUE_LO_IX  = 6'd5;
    localparam logic [KEPT_W-1:0] VALUE_HI_IX  = 6'd6;
    localparam logic [COUNT_W-1:0] WIDE_MIN    = 5'd2;
    localparam logic [SKIP_W-1:0] ECHO_SKIP_RESET = 4'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BYTE_W-1:0]  rx_byte;
        logic [COUNT_W-1:0] data_bytes;
    } in_item_t;

    typedef struct packed {
        logic               checksum_ok;
        logic [BYTE_W-1:0]  status_error;
        logic [VALUE_W-1:0] read_value;
        logic [KEPT_W-1:0]  bytes_received;
        logic               ended_early;
    } out_item_t;

    // Handshake between the assembly logic and the result register.
    typedef struct packed {
        logic load;
        logic space;
    } res_ctrl_t;

endpackage

// ----- sv/ssprx_in_stage.sv -----
// Input register stage that holds one accepted word until the assembly logic takes it.
module ssprx_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ssprx_pkg::in_item_t in_data,
    input  logic                take,
    output logic                item_valid,
    output ssprx_pkg::in_item_t item
);

    logic                valid_reg;
    logic                valid_next;
    ssprx_pkg::in_item_t item_reg;

    // The stage refills in the same cycle that the held word is taken.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/ssprx_core.sv -----
// Packet assembly: echo skipping, sync hunt, field capture and running checksum.
module ssprx_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [ssprx_pkg::SKIP_W-1:0]          cfg_wr_data,
    input  logic                                  item_valid,
    input  ssprx_pkg::in_item_t                   item,
    output logic                                  take,
    input  logic                                  res_space,
    output logic                                  res_load,
    output ssprx_pkg::out_item_t                  res
);

    logic [ssprx_pkg::SKIP_W-1:0] echo_skip_reg;
    logic                         active_reg,  active_next;
    logic [ssprx_pkg::SKIP_W-1:0] skip_reg,    skip_next;
    logic [ssprx_pkg::KEPT_W-1:0] kept_reg,    kept_next;
    logic [ssprx_pkg::KEPT_W-1:0] total_reg,   total_next;
    logic                         wide_reg,    wide_next;
    logic [ssprx_pkg::BYTE_W-1:0] sum_reg,     sum_next;
    logic [ssprx_pkg::BYTE_W-1:0] err_reg,     err_next;
    logic [ssprx_pkg::BYTE_W-1:0] vlo_reg,     vlo_next;
    logic [ssprx_pkg::BYTE_W-1:0] vhi_reg,     vhi_next;
    logic [ssprx_pkg::KEPT_W-1:0] total_raw;
    logic [ssprx_pkg::KEPT_W-1:0] kept_inc;
    logic                         emit;
    logic                         early;
    logic                         ok;

    assign total_raw = ssprx_pkg::KEPT_W'(item.data_bytes) + ssprx_pkg::HDR_BYTES;
    assign kept_inc  = kept_reg + 1'b1;

    always_comb
    begin
        active_next = active_reg;
        skip_next   = skip_reg;
        kept_next   = kept_reg;
        total_next  = total_reg;
        wide_next   = wide_reg;
        sum_next    = sum_reg;
        err_next    = err_reg;
        vlo_next    = vlo_reg;
        vhi_next    = vhi_reg;
        emit        = 1'b0;
        early       = 1'b0;
        unique case (item.func)
            ssprx_pkg::FUNC_START:
            begin
                active_next = 1'b1;
                skip_next   = echo_skip_reg;
                kept_next   = '0;
                if (total_raw > ssprx_pkg::KEPT_W'(ssprx_pkg::PACKET_BYTES_MAX))
                begin
                    total_next = ssprx_pkg::KEPT_W'(ssprx_pkg::PACKET_BYTES_MAX);
                end
                else
                begin
                    total_next = total_raw;
                end
                wide_next = (item.data_bytes >= ssprx_pkg::WIDE_MIN);
                sum_next  = '0;
                err_next  = '0;
                vlo_next  = '0;
                vhi_next  = '0;
            end
            ssprx_pkg::FUNC_BYTE:
            begin
                if (active_reg)
                begin
                    if (skip_reg != '0)
                    begin
                        skip_next = skip_reg - 1'b1;
                    end
                    else if (kept_reg != '0 || item.rx_byte == ssprx_pkg::SYNC_BYTE)
                    begin
                        if (kept_reg >= ssprx_pkg::SUM_FIRST_IX)
                        begin
                            sum_next = sum_reg + item.rx_byte;
                        end
                        if (kept_reg == ssprx_pkg::ERROR_IX)
                        begin
                            err_next = item.rx_byte;
                        end
                        if (kept_reg == ssprx_pkg::VALUE_LO_IX)
                        begin
                            vlo_next = item.rx_byte;
                        end
                        if (kept_reg == ssprx_pkg::VALUE_HI_IX)
                        begin
                            vhi_next = item.rx_byte;
                        end
                        kept_next = kept_inc;
                        if (kept_inc >= total_reg)
                        begin
                            emit        = 1'b1;
                            active_next = 1'b0;
                        end
                    end
                end
            end
            ssprx_pkg::FUNC_IDLE:
            begin
                if (active_reg)
                begin
                    emit        = 1'b1;
                    early       = 1'b1;
                    active_next = 1'b0;
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    // A word that yields no result may pass even while a result waits downstream.
    assign take     = item_valid && (!emit || res_space);
    assign res_load = take && emit;

    assign ok = (sum_next == ssprx_pkg::SUM_GOOD);
    assign res.checksum_ok    = ok;
    assign res.status_error   = err_next;
    assign res.read_value     = ok ? {(wide_reg ? vhi_next : {ssprx_pkg::BYTE_W{1'b0}}),
                                      vlo_next}
                                   : {ssprx_pkg::VALUE_W{1'b0}};
    assign res.bytes_received = kept_next;
    assign res.ended_early    = early;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_skip_reg <= ssprx_pkg::ECHO_SKIP_RESET;
        end
        else if (cfg_wr_en)
        begin
            echo_skip_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            skip_reg   <= '0;
            kept_reg   <= '0;
            total_reg  <= '0;
            wide_reg   <= 1'b0;
            sum_reg    <= '0;
            err_reg    <= '0;
            vlo_reg    <= '0;
            vhi_reg    <= '0;
        end
        else if (take)
        begin
            active_reg <= active_next;
            skip_reg   <= skip_next;
            kept_reg   <= kept_next;
            total_reg  <= total_next;
            wide_reg   <= wide_next;
            sum_reg    <= sum_next;
            err_reg    <= err_next;
            vlo_reg    <= vlo_next;
            vhi_reg    <= vhi_next;
        end
    end

endmodule

// ----- sv/ssprx_out_stage.sv -----
// Result register that holds one finished status word until the consumer takes it.
module ssprx_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssprx_pkg::res_ctrl_t ctrl_in,
    output ssprx_pkg::res_ctrl_t ctrl_out,
    input  ssprx_pkg::out_item_t res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ssprx_pkg::out_item_t out_data
);

    logic                 valid_reg;
    logic                 valid_next;
    ssprx_pkg::out_item_t data_reg;

    assign valid_next = ctrl_in.load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.load)
        begin
            data_reg <= res;
        end
    end

    always_comb
    begin
        ctrl_out       = '0;
        ctrl_out.space = !valid_reg || out_ready;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/servo_status_packet_receiver_top.sv -----
// Top level of the servo status packet receiver.
//
//   Channel  Signals                          Direction  Word
//   in       in_valid, in_ready, in_data      sink       func, rx_byte, data_bytes
//   out      out_valid, out_ready, out_data   source     status result
//   cfg      cfg_wr_en, cfg_wr_data           sink       echo skip count, no wait
//
// One input word is taken every cycle unless a packet-ending word is held back;
// the input register feeds the assembly logic, which writes the result register.
// Reset clears the packet state and sets the echo skip count to four.
// While a result waits, words that end no packet still pass; a word that ends
// a packet holds in the input register until the result register frees.
module servo_status_packet_receiver_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ssprx_pkg::in_item_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ssprx_pkg::out_item_t          out_data,
    input  logic                          cfg_wr_en,
    input  logic [ssprx_pkg::SKIP_W-1:0]  cfg_wr_data
);

    logic                 take;
    logic                 item_valid;
    ssprx_pkg::in_item_t  item;
    ssprx_pkg::out_item_t res;
    ssprx_pkg::res_ctrl_t to_out;
    ssprx_pkg::res_ctrl_t from_out;
    logic                 res_load;

    ssprx_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ssprx_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take),
        .res_space   (from_out.space),
        .res_load    (res_load),
        .res         (res)
    );

    always_comb
    begin
        to_out       = '0;
        to_out.load  = res_load;
    end

    ssprx_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_in   (to_out),
        .ctrl_out  (from_out),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- sv/ssprx_checker.sv -----
// Port-level checker for the servo status packet receiver, bound to the top level.
module ssprx_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  ssprx_pkg::out_item_t out_data
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // A bad checksum never reports a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.checksum_ok |-> out_data.read_value == '0)
        else $error("value reported with a bad checksum");

    // The kept length never passes the clamp.
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.bytes_received
            <= ssprx_pkg::KEPT_W'(ssprx_pkg::PACKET_BYTES_MAX))
        else $error("byte count above the packet limit");

    // A packet that completed holds at least the header and checksum.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ended_early
            |-> out_data.bytes_received >= ssprx_pkg::HDR_BYTES)
        else $error("complete packet shorter than its header");

    // The error byte is zero until its position has arrived.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bytes_received <= ssprx_pkg::ERROR_IX
            |-> out_data.status_error == '0)
        else $error("error byte reported before it arrived");

endmodule

bind servo_status_packet_receiver_top ssprx_checker u_ssprx_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
